// ===== src/bsp_pkg.sv =====
// Shared types and constants for the quadratic B-spline curve evaluator.
package bsp_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned SAMP_W     = 16;
  localparam int unsigned NCTL_W     = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CONTROL = 1'b0,
    CFG_NUM_SAMPLES = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_EVAL  = 1'b1
  } req_e;

  typedef enum logic {
    ST_OK    = 1'b0,
    ST_RANGE = 1'b1
  } status_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

endpackage

// ===== src/bsp_if.sv =====
// Handshake channel interfaces: request, result and configuration write.
interface bsp_req_if;
  import bsp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [IDX_W-1:0]          point_index;
  logic [SAMP_W-1:0]         sample_index;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  modport source (output valid, req_type, point_index, sample_index, coord_x, coord_y,
                  coord_z, input ready);
  modport sink (input valid, req_type, point_index, sample_index, coord_x, coord_y,
                coord_z, output ready);
endinterface

interface bsp_res_if;
  import bsp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic                      status;
  modport source (output valid, pos_x, pos_y, pos_z, status, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, status, output ready);
endinterface

interface bsp_cfg_if;
  import bsp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/bsp_div.sv =====
// Bit-serial restoring divider forming floor(num * 2^FRAC_BITS / den) for num < den.
module bsp_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bsp_pkg::SAMP_W-1:0]    num_i,
  input  logic [bsp_pkg::SAMP_W-1:0]    den_i,
  output logic                          done_o,
  output logic [FRAC_BITS-1:0]          quo_o
);
  import bsp_pkg::*;

  localparam int unsigned CW = $clog2(FRAC_BITS + 1);

  logic [SAMP_W-1:0]    rem_q, rem_d;
  logic [SAMP_W-1:0]    den_q;
  logic [FRAC_BITS-1:0] quo_q;
  logic [CW-1:0]        cnt_q;
  logic                 run_q, done_q;
  logic [SAMP_W:0]      rem2;
  logic                 qbit;

  always_comb begin
    rem2 = {rem_q, 1'b0};
    qbit = (rem2 >= {1'b0, den_q});
    rem_d = qbit ? SAMP_W'(rem2 - {1'b0, den_q}) : rem2[SAMP_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == CW'(1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(FRAC_BITS);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[FRAC_BITS-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// ===== src/bsp_mem.sv =====
// Control point store: one write port, one registered read port.
module bsp_mem #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned AW         = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  bsp_pkg::point_t  wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output bsp_pkg::point_t  rdata_o
);
  import bsp_pkg::*;

  point_t mem_q [MAX_POINTS];
  point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== src/quadratic_bspline_curve_eval_top.sv =====
// Top level: quadratic B-spline curve evaluator with shared multiplier sequencer.
//
//   channel | dir | beat
//   req_i   | in  | write point (req_type 0) or evaluate sample (req_type 1)
//   res_o   | out | pos_x, pos_y, pos_z, status; one beat per evaluate
//   cfg_i   | in  | index 0 num_control, index 1 num_samples
//
// A point write is stored at its request beat. An evaluate runs the bit-serial divider,
// then the sequencer issues 14 passes through the one shared multiplier (span, four basis
// products, nine point products), then accumulate and output load; the next request is
// taken once the result is loaded. An out-of-range sample skips the divider and sequencer
// and goes straight to output load. Reset clears control state only; the point store is
// undefined until written. A stalled result holds in the output register while the next
// request is taken.
module quadratic_bspline_curve_eval_top #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  bsp_req_if.sink   req_i,
  bsp_res_if.source res_o,
  bsp_cfg_if.sink   cfg_i
);
  import bsp_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned AW_   = 33;
  localparam int unsigned BW    = FRAC_BITS + 3;
  localparam int unsigned PW    = AW_ + BW;
  localparam int unsigned WW    = FRAC_BITS + 2;
  localparam int unsigned TW    = PW - FRAC_BITS;
  localparam int unsigned ACC_W = TW + 2;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_DIV  = 12'b000000000010,
    S_TT   = 12'b000000000100,
    S_SPAN = 12'b000000001000,
    S_B0   = 12'b000000010000,
    S_B1   = 12'b000000100000,
    S_B2   = 12'b000001000000,
    S_B3   = 12'b000010000000,
    S_B4   = 12'b000100000000,
    S_PM   = 12'b001000000000,
    S_ACC  = 12'b010000000000,
    S_DONE = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic [NCTL_W-1:0]    num_control_q;
  logic [SAMP_W-1:0]    num_samples_q;
  logic [NCTL_W-1:0]    n_cl, m_cl;
  logic                 req_acc, wr_ok, eval_ok;
  logic                 div_start, div_done;
  logic [FRAC_BITS-1:0] quo, t_q;
  logic [NCTL_W-1:0]    s_q;
  logic [FRAC_BITS-1:0] u_q;
  logic [FRAC_BITS:0]   one_v, omu;
  logic                 d1_two, d2_two;
  logic [WW-1:0]        r0, r1a, r1b, r2;
  logic [WW-1:0]        w0_q, w1_q, w2_q, wtmp_q, w_sel, wprod;
  logic signed [AW_-1:0] mul_a;
  logic signed [BW-1:0]  mul_b;
  logic signed [PW-1:0]  prod_q;
  logic signed [TW-1:0]  term;
  logic signed [ACC_W-1:0] acc_q [3];
  logic [1:0]           c_q, pt_q, acc_c_q;
  logic                 acc_en_q, flag_q;
  logic                 rd_en;
  logic [NCTL_W:0]      rd_j;
  point_t               rdata, wdata;
  logic signed [COORD_W-1:0] coord;
  logic                 res_valid_q, res_status_q, out_free;
  logic signed [COORD_W-1:0] pos_q [3];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_control_q <= NCTL_W'(3);
      num_samples_q <= SAMP_W'(100);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_NUM_CONTROL: num_control_q <= cfg_i.data[NCTL_W-1:0];
        CFG_NUM_SAMPLES: num_samples_q <= cfg_i.data;
        default: ;
      endcase
    end
  end
  assign cfg_i.ready = 1'b1;

  always_comb begin
    if (num_control_q < NCTL_W'(3)) begin
      n_cl = NCTL_W'(3);
    end else if (32'(num_control_q) > 32'(MAX_POINTS)) begin
      n_cl = NCTL_W'(MAX_POINTS);
    end else begin
      n_cl = num_control_q;
    end
    m_cl = n_cl - NCTL_W'(2);
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign wr_ok       = req_acc && (req_i.req_type == REQ_WRITE) &&
                       (32'(req_i.point_index) < 32'(MAX_POINTS));
  assign eval_ok     = req_i.sample_index < num_samples_q;
  assign div_start   = req_acc && (req_i.req_type == REQ_EVAL) && eval_ok;

  bsp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (req_i.sample_index),
    .den_i   (num_samples_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign wdata = '{x: req_i.coord_x, y: req_i.coord_y, z: req_i.coord_z};

  bsp_mem #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_ok),
    .waddr_i (AW'(req_i.point_index)),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (AW'(rd_j)),
    .rdata_o (rdata)
  );

  // basis ratios; knot differences are one or two
  always_comb begin
    one_v  = {1'b1, {FRAC_BITS{1'b0}}};
    omu    = one_v - {1'b0, u_q};
    d1_two = (s_q != '0);
    d2_two = ((NCTL_W+1)'(s_q) + (NCTL_W+1)'(2)) <= (NCTL_W+1)'(m_cl);
    r0     = d1_two ? WW'(omu >> 1) : WW'(omu);
    r1a    = d1_two ? WW'(({1'b0, u_q} + one_v) >> 1) : WW'(u_q);
    r1b    = d2_two ? WW'(({1'b0, one_v} + {2'b0, omu}) >> 1) : WW'(omu);
    r2     = d2_two ? WW'(u_q >> 1) : WW'(u_q);
  end

  always_comb begin
    case (pt_q)
      2'd0:    w_sel = w0_q;
      2'd1:    w_sel = w1_q;
      default: w_sel = w2_q;
    endcase
    case (c_q)
      2'd0:    coord = rdata.x;
      2'd1:    coord = rdata.y;
      default: coord = rdata.z;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_TT: begin
        mul_a = signed'(AW_'(t_q));
        mul_b = signed'(BW'(m_cl));
      end
      S_B0: begin
        mul_a = signed'(AW_'(r0));
        mul_b = signed'(BW'(omu));
      end
      S_B1: begin
        mul_a = signed'(AW_'(r1a));
        mul_b = signed'(BW'(omu));
      end
      S_B2: begin
        mul_a = signed'(AW_'(r1b));
        mul_b = signed'(BW'(u_q));
      end
      S_B3: begin
        mul_a = signed'(AW_'(r2));
        mul_b = signed'(BW'(u_q));
      end
      S_PM: begin
        mul_a = AW_'(coord);
        mul_b = signed'(BW'(w_sel));
      end
      default: ;
    endcase
  end

  assign wprod = prod_q[2*FRAC_BITS+1:FRAC_BITS];
  assign term  = prod_q[PW-1:FRAC_BITS];

  always_comb begin
    rd_en = 1'b0;
    rd_j  = {1'b0, s_q};
    if (state_q == S_B4) begin
      rd_en = 1'b1;
    end else if (state_q == S_PM && c_q == 2'd2 && pt_q != 2'd2) begin
      rd_en = 1'b1;
      rd_j  = {1'b0, s_q} + (NCTL_W+1)'(pt_q) + (NCTL_W+1)'(1);
    end
  end

  assign out_free = !res_valid_q || res_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_acc && req_i.req_type == REQ_EVAL) begin
          state_d = eval_ok ? S_DIV : S_DONE;
        end
      end
      S_DIV:  if (div_done) state_d = S_TT;
      S_TT:   state_d = S_SPAN;
      S_SPAN: state_d = S_B0;
      S_B0:   state_d = S_B1;
      S_B1:   state_d = S_B2;
      S_B2:   state_d = S_B3;
      S_B3:   state_d = S_B4;
      S_B4:   state_d = S_PM;
      S_PM:   if (c_q == 2'd2 && pt_q == 2'd2) state_d = S_ACC;
      S_ACC:  state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      acc_en_q    <= 1'b0;
      c_q         <= '0;
      pt_q        <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      acc_en_q <= (state_q == S_PM);
      if (state_q == S_B4) begin
        c_q  <= '0;
        pt_q <= '0;
      end else if (state_q == S_PM) begin
        if (c_q == 2'd2) begin
          c_q  <= '0;
          pt_q <= pt_q + 2'd1;
        end else begin
          c_q <= c_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= PW'(mul_a) * PW'(mul_b);
    acc_c_q <= c_q;
    if (state_q == S_IDLE && req_acc) begin
      flag_q <= !eval_ok;
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= '0;
      end
    end
    if (div_done) t_q <= quo;
    if (state_q == S_SPAN) begin
      s_q <= prod_q[FRAC_BITS+NCTL_W-1:FRAC_BITS];
      u_q <= prod_q[FRAC_BITS-1:0];
    end
    if (state_q == S_B1) w0_q <= wprod;
    if (state_q == S_B2) wtmp_q <= wprod;
    if (state_q == S_B3) w1_q <= wtmp_q + wprod;
    if (state_q == S_B4) w2_q <= wprod;
    if (acc_en_q) begin
      acc_q[acc_c_q] <= acc_q[acc_c_q] + ACC_W'(term);
    end
    if (state_q == S_DONE && out_free) begin
      res_status_q <= flag_q;
      for (int i = 0; i < 3; i++) begin
        if (acc_q[i][ACC_W-1:COORD_W-1] != '0 && acc_q[i][ACC_W-1:COORD_W-1] != '1) begin
          pos_q[i] <= acc_q[i][ACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                        : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
          pos_q[i] <= acc_q[i][COORD_W-1:0];
        end
      end
    end
  end

  assign res_o.valid  = res_valid_q;
  assign res_o.status = res_status_q;
  assign res_o.pos_x  = pos_q[0];
  assign res_o.pos_y  = pos_q[1];
  assign res_o.pos_z  = pos_q[2];
endmodule

// ===== src/bsp_chk.sv =====
// Port-level checks for the curve evaluator, bound to the top level.
module bsp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_type,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] pos_x,
  input logic [31:0] pos_y,
  input logic [31:0] pos_z,
  input logic        res_status
);
  import bsp_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid) else $error("result beat dropped");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> $stable(pos_x) && $stable(res_status))
    else $error("stalled result changed");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_status == ST_RANGE |-> pos_x == '0 && pos_y == '0 && pos_z == '0)
    else $error("range status with nonzero position");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready && req_type == REQ_EVAL |=> !req_ready)
    else $error("ready during evaluation");
endmodule

bind quadratic_bspline_curve_eval_top bsp_chk u_bsp_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid  (req_i.valid),
  .req_ready  (req_i.ready),
  .req_type   (req_i.req_type),
  .res_valid  (res_o.valid),
  .res_ready  (res_o.ready),
  .pos_x      (res_o.pos_x),
  .pos_y      (res_o.pos_y),
  .pos_z      (res_o.pos_z),
  .res_status (res_o.status)
);
